>>> sv/fmfp_pkg.sv
// Package with shared types and constants for the frog model first-passage simulator.
package fmfp_pkg;

   localparam logic [63:0] RNG_MULT = 64'h2545F4914F6CDD1D;

   // Coordinate range that the geometry registers must stay inside.
   localparam int COORD_BITS = 16;

   localparam logic [2:0] REG_INIT_X_LOW  = 3'd0;
   localparam logic [2:0] REG_INIT_X_HIGH = 3'd1;
   localparam logic [2:0] REG_BOX_X_LOW   = 3'd2;
   localparam logic [2:0] REG_BOX_X_HIGH  = 3'd3;
   localparam logic [2:0] REG_Y_HALF      = 3'd4;
   localparam logic [2:0] REG_TARGET_X    = 3'd5;
   localparam logic [2:0] REG_STEP_LIMIT  = 3'd6;

   localparam logic [1:0] ST_REACHED  = 2'd0;
   localparam logic [1:0] ST_LIMIT    = 2'd1;
   localparam logic [1:0] ST_OVERFLOW = 2'd2;

   typedef enum logic [4:0] {
      S_IDLE,
      S_CHECK,
      S_CLEAR,
      S_START,
      S_MOVE_RD,
      S_MOVE_WAIT,
      S_MOVE_RNG,
      S_MOVE_MUL,
      S_MOVE_WR,
      S_SCAN_RD,
      S_SCAN_WAIT,
      S_SCAN_IDX,
      S_SCAN_MAP,
      S_SCAN_DEC,
      S_TICK_END,
      S_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_seed;   // load the generator and check the geometry
      logic clear_step;  // clear one visited word, advance the clear address
      logic start_run;   // place frog zero and mark the origin
      logic rd_frog;     // read frog at the frog index
      logic rng_step;    // advance the generator
      logic mul_step;    // register the scrambled draw
      logic wr_move;     // write moved frog back, advance index
      logic idx_step;    // compute the window index of the current frog
      logic map_rd;      // read the visited word
      logic scan_commit; // mark, append or advance the scan index
      logic tick_begin;  // start of a tick: reset the frog index, advance the tick count
      logic tick_scan;   // end of move pass: latch old count
      logic set_result;  // capture the result
   } cmd_type;

   typedef struct packed {
      logic geom_bad;
      logic target_zero;
      logic clear_done;
      logic move_last;
      logic scan_last;
      logic hit_target;
      logic ovf;
      logic limit_hit;
   } status_type;

endpackage

>>> sv/frog_model_first_passage_sim.sv
// Top level of the frog model first-passage simulator.
// Each accepted seed starts one run and gives one transfer of first_time and
// status. A run first clears the visited map one 64-bit word per cycle, then
// on each tick moves every awake frog (store read, read wait, generator step,
// scrambling multiply, write back) and then scans every previously awake frog
// against the visited map (store read, read wait, window index, map read,
// commit). A new seed is taken only after the previous result has been
// transferred.
module frog_model_first_passage_sim #(
   parameter int MAX_FROGS  = 65536,
   parameter int VISIT_BITS = 1048576
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_seed,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [30:0] rsp_first_time,
   output logic [1:0]  rsp_status,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import fmfp_pkg::*;

   cmd_type    cmd;
   status_type stat;

   logic signed [15:0] init_x_low_ff, box_x_low_ff;
   logic [14:0]        init_x_high_ff, box_x_high_ff, y_half_ff, target_x_ff;
   logic [30:0]        step_limit_ff;
   logic [2:0]         reg_sel;

   assign csr_pready = 1'b1;
   assign reg_sel    = csr_paddr[4:2];

   // Configuration registers; written in the access phase of a transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         init_x_low_ff  <= -16'sd100;
         init_x_high_ff <= 15'd1100;
         box_x_low_ff   <= -16'sd200;
         box_x_high_ff  <= 15'd1200;
         y_half_ff      <= 15'd177;
         target_x_ff    <= 15'd1000;
         step_limit_ff  <= 31'd200000;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (reg_sel)
            REG_INIT_X_LOW:  init_x_low_ff  <= csr_pwdata[15:0];
            REG_INIT_X_HIGH: init_x_high_ff <= csr_pwdata[14:0];
            REG_BOX_X_LOW:   box_x_low_ff   <= csr_pwdata[15:0];
            REG_BOX_X_HIGH:  box_x_high_ff  <= csr_pwdata[14:0];
            REG_Y_HALF:      y_half_ff      <= csr_pwdata[14:0];
            REG_TARGET_X:    target_x_ff    <= csr_pwdata[14:0];
            REG_STEP_LIMIT:  step_limit_ff  <= csr_pwdata[30:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_INIT_X_LOW:  csr_prdata = 32'(init_x_low_ff);
         REG_INIT_X_HIGH: csr_prdata = 32'(init_x_high_ff);
         REG_BOX_X_LOW:   csr_prdata = 32'(box_x_low_ff);
         REG_BOX_X_HIGH:  csr_prdata = 32'(box_x_high_ff);
         REG_Y_HALF:      csr_prdata = 32'(y_half_ff);
         REG_TARGET_X:    csr_prdata = 32'(target_x_ff);
         REG_STEP_LIMIT:  csr_prdata = 32'(step_limit_ff);
         default:         csr_prdata = '0;
      endcase
   end

   fmfp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   fmfp_datapath #(
      .MAX_FROGS  (MAX_FROGS),
      .VISIT_BITS (VISIT_BITS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .seed          (req_seed),
      .init_x_low    (init_x_low_ff),
      .init_x_high   (init_x_high_ff),
      .box_x_low     (box_x_low_ff),
      .box_x_high    (box_x_high_ff),
      .y_half_height (y_half_ff),
      .target_x      (target_x_ff),
      .step_limit    (step_limit_ff),
      .cmd           (cmd),
      .stat          (stat),
      .first_time    (rsp_first_time),
      .status        (rsp_status)
   );

endmodule

>>> sv/fmfp_ctrl.sv
// Controller state machine that sequences one run of the simulator.
module fmfp_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  fmfp_pkg::status_type  stat,
   output fmfp_pkg::cmd_type     cmd
);
   import fmfp_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign req_stall = (state_ff != S_IDLE) || rsp_valid_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == S_DONE) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && !rsp_valid_ff) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (stat.target_zero || stat.geom_bad) begin
               state_in = S_DONE;
            end else begin
               state_in = S_CLEAR;
            end
         end
         S_CLEAR: begin
            if (stat.clear_done) begin
               state_in = S_START;
            end
         end
         S_START:     state_in = S_TICK_END;
         S_MOVE_RD:   state_in = S_MOVE_WAIT;
         S_MOVE_WAIT: state_in = S_MOVE_RNG;
         S_MOVE_RNG:  state_in = S_MOVE_MUL;
         S_MOVE_MUL:  state_in = S_MOVE_WR;
         S_MOVE_WR: begin
            if (stat.move_last) begin
               state_in = S_SCAN_RD;
            end else begin
               state_in = S_MOVE_RD;
            end
         end
         S_SCAN_RD:   state_in = S_SCAN_WAIT;
         S_SCAN_WAIT: state_in = S_SCAN_IDX;
         S_SCAN_IDX:  state_in = S_SCAN_MAP;
         S_SCAN_MAP:  state_in = S_SCAN_DEC;
         S_SCAN_DEC: begin
            if (stat.hit_target) begin
               state_in = S_DONE;
            end else if (stat.scan_last) begin
               state_in = S_TICK_END;
            end else begin
               state_in = S_SCAN_RD;
            end
         end
         S_TICK_END: begin
            if (stat.ovf || stat.limit_hit) begin
               state_in = S_DONE;
            end else begin
               state_in = S_MOVE_RD;
            end
         end
         S_DONE:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         S_IDLE:      cmd.load_seed = req_valid && !rsp_valid_ff;
         S_CLEAR:     cmd.clear_step = 1'b1;
         S_START:     cmd.start_run = 1'b1;
         S_MOVE_RD:   cmd.rd_frog = 1'b1;
         S_MOVE_RNG:  cmd.rng_step = 1'b1;
         S_MOVE_MUL:  cmd.mul_step = 1'b1;
         S_MOVE_WR: begin
            cmd.wr_move   = 1'b1;
            cmd.tick_scan = stat.move_last;
         end
         S_SCAN_RD:   cmd.rd_frog = 1'b1;
         S_SCAN_IDX:  cmd.idx_step = 1'b1;
         S_SCAN_MAP:  cmd.map_rd = 1'b1;
         S_SCAN_DEC:  cmd.scan_commit = 1'b1;
         S_TICK_END:  cmd.tick_begin = !(stat.ovf || stat.limit_hit);
         S_DONE:      cmd.set_result = 1'b1;
         default:     cmd = '0;
      endcase
   end

endmodule

>>> sv/fmfp_datapath.sv
// Datapath with the generator, frog stores, visited map and result registers.
module fmfp_datapath #(
   parameter int MAX_FROGS  = 65536,
   parameter int VISIT_BITS = 1048576
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [63:0]           seed,
   input  logic signed [15:0]    init_x_low,
   input  logic [14:0]           init_x_high,
   input  logic signed [15:0]    box_x_low,
   input  logic [14:0]           box_x_high,
   input  logic [14:0]           y_half_height,
   input  logic [14:0]           target_x,
   input  logic [30:0]           step_limit,
   input  fmfp_pkg::cmd_type     cmd,
   output fmfp_pkg::status_type  stat,
   output logic [30:0]           first_time,
   output logic [1:0]            status
);
   import fmfp_pkg::*;

   localparam int FI_W  = $clog2(MAX_FROGS);
   localparam int CNT_W = FI_W + 1;
   localparam int VI_W  = $clog2(VISIT_BITS);
   localparam int WORDS = (VISIT_BITS + 63) / 64;
   localparam int WA_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int WC_W  = WA_W + 1;
   localparam logic signed [17:0] LIM = 18'sd1 <<< (COORD_BITS - 1);

   // Coordinates are held as 17-bit signed values; the check keeps them in range.
   logic signed [16:0] fx_mem [MAX_FROGS];
   logic signed [16:0] fy_mem [MAX_FROGS];
   logic [63:0]        vmap   [WORDS];

   logic [63:0]        rng_ff, rng_in;
   logic [1:0]         draw_ff;
   logic [CNT_W-1:0]   awake_ff, old_ff, idx_ff;
   logic [30:0]        tick_ff;
   logic [WC_W-1:0]    clr_ff;
   logic               ovf_ff, bad_ff;
   logic signed [16:0] rx_ff, ry_ff;
   logic [16:0]        wdt_ff;
   logic [VI_W:0]      vidx_ff;
   logic               inwin_ff, tgt_ff;
   logic [63:0]        vword_ff;
   logic [30:0]        first_ff;
   logic [1:0]         status_ff;

   logic signed [17:0] ixl, ixh, bxl, bxh, yh;
   logic [35:0]        area;

   assign ixl = 18'(init_x_low);
   assign ixh = 18'($signed({1'b0, init_x_high}));
   assign bxl = 18'(box_x_low);
   assign bxh = 18'($signed({1'b0, box_x_high}));
   assign yh  = 18'($signed({1'b0, y_half_height}));
   // Width times height of the window; one narrow multiply.
   assign area = 36'(ixh - ixl + 18'sd1) * 36'({yh[16:0], 1'b1});

   // Generator update.
   logic [63:0] t1, t2, t3;
   always_comb begin
      t1 = rng_ff ^ (rng_ff >> 12);
      t2 = t1 ^ (t1 << 25);
      t3 = t2 ^ (t2 >> 27);
      rng_in = cmd.load_seed ? (seed | 64'd1) : (cmd.rng_step ? t3 : rng_ff);
   end

   // Only the low two bits of the scrambled draw matter; the product's low
   // bits depend only on the low bits of the operands.
   logic [1:0] dir;
   assign dir = draw_ff;

   function automatic logic signed [16:0] wall(input logic signed [17:0] v,
                                                input logic signed [17:0] lo,
                                                input logic signed [17:0] hi);
      logic signed [17:0] r;
      begin
         r = v;
         if (r > hi) r = 18'(2 * hi - r);
         else if (r < lo) r = 18'(2 * lo - r);
         if (r < lo) r = lo;
         if (r > hi) r = hi;
         return r[16:0];
      end
   endfunction

   logic signed [17:0] nx, ny;
   logic signed [16:0] mx, my;
   always_comb begin
      nx = 18'(rx_ff);
      ny = 18'(ry_ff);
      case (dir)
         2'd0:    nx = nx + 18'sd1;
         2'd1:    nx = nx - 18'sd1;
         2'd2:    ny = ny + 18'sd1;
         default: ny = ny - 18'sd1;
      endcase
      mx = wall(nx, bxl, bxh);
      my = wall(ny, -yh, yh);
   end

   logic [FI_W-1:0] faddr;
   assign faddr = idx_ff[FI_W-1:0];

   logic [VI_W-1:0] vbit;
   assign vbit = vidx_ff[VI_W-1:0];
   logic [WA_W-1:0] vw;
   assign vw = WA_W'(vbit >> 6);

   logic marked, append;
   assign marked = inwin_ff && !vword_ff[vbit[5:0]];
   assign append = marked && !tgt_ff && (awake_ff < CNT_W'(MAX_FROGS));

   // Frog stores: one write port, one read port.
   always_ff @(posedge clock) begin
      if (cmd.start_run) begin
         fx_mem[0] <= '0;
         fy_mem[0] <= '0;
      end else if (cmd.wr_move) begin
         fx_mem[faddr] <= mx;
         fy_mem[faddr] <= my;
      end else if (cmd.scan_commit && append) begin
         fx_mem[awake_ff[FI_W-1:0]] <= rx_ff;
         fy_mem[awake_ff[FI_W-1:0]] <= ry_ff;
      end
      if (cmd.rd_frog) begin
         rx_ff <= fx_mem[faddr];
         ry_ff <= fy_mem[faddr];
      end
   end

   // Visited map as 64-bit words. The origin is marked only when it lies in the window.
   logic [VI_W:0]   oidx;
   logic [VI_W-1:0] obit;
   assign oidx = (VI_W + 1)'(18'sd0 - ixl);
   assign obit = oidx[VI_W-1:0] + VI_W'(VI_W'(yh) * VI_W'(wdt_ff));
   always_ff @(posedge clock) begin
      if (cmd.clear_step) begin
         vmap[clr_ff[WA_W-1:0]] <= '0;
      end else if (cmd.start_run && (ixl <= 18'sd0)) begin
         vmap[WA_W'(obit >> 6)] <= 64'd1 << obit[5:0];
      end else if (cmd.scan_commit && marked) begin
         vmap[vw] <= vword_ff | (64'd1 << vbit[5:0]);
      end
      if (cmd.map_rd) begin
         vword_ff <= vmap[vw];
      end
   end

   always_ff @(posedge clock) begin
      rng_ff <= rng_in;
      if (cmd.mul_step) begin
         draw_ff <= rng_ff[1:0] * RNG_MULT[1:0];
      end
      if (cmd.load_seed) begin
         wdt_ff <= 17'(ixh - ixl + 18'sd1);
         bad_ff <= (ixl < -LIM) || (ixh > LIM - 18'sd1) || (bxl < -LIM) ||
                   (bxh > LIM - 18'sd1) || (yh > LIM - 18'sd1) ||
                   (ixh - ixl + 18'sd1 <= 18'sd0) ||
                   (area > 36'(VISIT_BITS)) || (step_limit == '0);
      end
      if (cmd.idx_step) begin
         inwin_ff <= (18'(rx_ff) >= ixl) && (18'(rx_ff) <= ixh) &&
                     (18'(ry_ff) >= -yh) && (18'(ry_ff) <= yh);
         vidx_ff  <= (VI_W + 1)'(18'(ry_ff) + yh) * (VI_W + 1)'(wdt_ff)
                     + (VI_W + 1)'(18'(rx_ff) - ixl);
         tgt_ff   <= (18'(rx_ff) == 18'($signed({1'b0, target_x}))) && (ry_ff == '0);
      end
      if (cmd.set_result) begin
         if (target_x == '0) begin
            first_ff <= '0; status_ff <= ST_REACHED;
         end else if (bad_ff) begin
            first_ff <= '0; status_ff <= ST_OVERFLOW;
         end else if (marked && tgt_ff) begin
            first_ff <= tick_ff; status_ff <= ST_REACHED;
         end else if (ovf_ff) begin
            first_ff <= '0; status_ff <= ST_OVERFLOW;
         end else begin
            first_ff <= '0; status_ff <= ST_LIMIT;
         end
      end
   end

   // Control counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         awake_ff <= '0;
         old_ff   <= '0;
         idx_ff   <= '0;
         tick_ff  <= '0;
         clr_ff   <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         if (cmd.load_seed) begin
            clr_ff <= '0;
         end else if (cmd.clear_step) begin
            clr_ff <= clr_ff + WC_W'(1);
         end
         if (cmd.load_seed) begin
            tick_ff <= '0;
         end else if (cmd.tick_begin) begin
            tick_ff <= tick_ff + 31'd1;
         end
         if (cmd.load_seed) begin
            ovf_ff <= 1'b0;
         end else if (cmd.scan_commit && marked && !tgt_ff && !append) begin
            ovf_ff <= 1'b1;
         end
         if (cmd.start_run) begin
            awake_ff <= CNT_W'(1);
         end else if (cmd.scan_commit && append) begin
            awake_ff <= awake_ff + CNT_W'(1);
         end
         if (cmd.tick_scan) begin
            old_ff <= awake_ff;
         end
         if (cmd.tick_begin || cmd.tick_scan) begin
            idx_ff <= '0;
         end else if (cmd.wr_move || cmd.scan_commit) begin
            idx_ff <= idx_ff + CNT_W'(1);
         end
      end
   end

   assign stat.geom_bad    = bad_ff;
   assign stat.target_zero = (target_x == '0);
   assign stat.clear_done  = (clr_ff == WC_W'(WORDS - 1));
   assign stat.move_last   = (idx_ff + CNT_W'(1) == awake_ff);
   assign stat.scan_last   = (idx_ff + CNT_W'(1) == old_ff);
   assign stat.hit_target  = marked && tgt_ff;
   assign stat.ovf         = ovf_ff;
   assign stat.limit_hit   = (tick_ff == step_limit);

   assign first_time = first_ff;
   assign status     = status_ff;

endmodule

>>> test/frog_model_first_passage_sim_tb.sv
// Testbench for the frog model first-passage simulator: seeded runs checked against a predictor.
module frog_model_first_passage_sim_tb;
   import fmfp_pkg::*;

   localparam int       FROG_CAP  = 65536;
   localparam longint   MAP_SITES = 1048576;
   localparam int       HALF_PER  = 6;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [63:0] req_seed;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [30:0] rsp_first_time;
   logic [1:0]  rsp_status;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [4:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   frog_model_first_passage_sim u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_seed(req_seed),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_first_time(rsp_first_time), .rsp_status(rsp_status),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   typedef struct packed {
      logic [30:0] first_time;
      logic [1:0]  status;
   } outcome_type;

   // Seeds waiting to be driven, and run outcomes waiting to come back.
   logic [63:0] seed_queue[$];
   outcome_type outcome_queue[$];

   // Shadow copy of the geometry registers, taken from the values written.
   int          win_lo, win_hi, box_lo, box_hi, half_h, goal_x;
   longint      tick_limit;

   // Predictor working state for one run.
   logic [63:0] gen_word;
   int          frog_x[$];
   int          frog_y[$];
   bit          site_seen[longint];

   int          errors;
   int          checked;
   int          reached_runs, limit_runs, bad_runs;
   longint      cycle_count;
   bit          req_fire;

   always begin
      clock = 1'b1;
      #(HALF_PER);
      clock = 1'b0;
      #(HALF_PER);
   end

   function automatic int reflect(input int v, input int lo, input int hi);
      if (v > hi) v = 2 * hi - v;
      else if (v < lo) v = 2 * lo - v;
      if (v < lo) v = lo;
      if (v > hi) v = hi;
      return v;
   endfunction

   // Marks a site of the initial window; returns 1 only when it was not marked yet.
   function automatic bit claim_site(input int x, input int y);
      longint width, slot;
      width = longint'(win_hi) - longint'(win_lo) + 1;
      if (x < win_lo || x > win_hi || y < -half_h || y > half_h) return 1'b0;
      slot = longint'(y + half_h) * width + longint'(x - win_lo);
      if (slot >= MAP_SITES) return 1'b0;
      if (site_seen.exists(slot)) return 1'b0;
      site_seen[slot] = 1'b1;
      return 1'b1;
   endfunction

   // Works out the whole first-passage run for one seed.
   function automatic outcome_type first_passage(input logic [63:0] seed);
      outcome_type res;
      longint      width, height, tick;
      int          alive, i, x, y, nx, ny;
      logic [63:0] scrambled;
      logic [1:0]  dir;
      bit          spilled;
      res.first_time = '0;
      res.status     = ST_OVERFLOW;
      gen_word = seed | 64'd1;
      if (goal_x == 0) begin
         res.status = ST_REACHED;
         return res;
      end
      if (tick_limit == 0) return res;
      width  = longint'(win_hi) - longint'(win_lo) + 1;
      height = 2 * longint'(half_h) + 1;
      if (width <= 0 || width * height > MAP_SITES) return res;
      site_seen.delete();
      frog_x = {0};
      frog_y = {0};
      void'(claim_site(0, 0));
      for (tick = 1; tick <= tick_limit; tick++) begin
         for (i = 0; i < frog_x.size(); i++) begin
            gen_word  = gen_word ^ (gen_word >> 12);
            gen_word  = gen_word ^ (gen_word << 25);
            gen_word  = gen_word ^ (gen_word >> 27);
            scrambled = gen_word * RNG_MULT;
            dir = scrambled[1:0];
            nx = frog_x[i] + ((dir == 2'd0) ? 1 : (dir == 2'd1) ? -1 : 0);
            ny = frog_y[i] + ((dir == 2'd2) ? 1 : (dir == 2'd3) ? -1 : 0);
            frog_x[i] = reflect(nx, box_lo, box_hi);
            frog_y[i] = reflect(ny, -half_h, half_h);
         end
         alive   = frog_x.size();
         spilled = 1'b0;
         for (i = 0; i < alive; i++) begin
            x = frog_x[i];
            y = frog_y[i];
            if (claim_site(x, y)) begin
               if (x == goal_x && y == 0) begin
                  res.first_time = tick[30:0];
                  res.status     = ST_REACHED;
                  return res;
               end
               if (frog_x.size() >= FROG_CAP) spilled = 1'b1;
               else begin
                  frog_x.push_back(x);
                  frog_y.push_back(y);
               end
            end
         end
         if (spilled) return res;
      end
      res.status = ST_LIMIT;
      return res;
   endfunction

   // One APB write: setup cycle, then access cycle with pready always high.
   task automatic csr_write(input logic [2:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Programs all seven registers and mirrors them in the predictor.
   task automatic set_geometry(input int wl, input int wh, input int bl, input int bh,
                               input int hh, input int gx, input longint lim);
      csr_write(REG_INIT_X_LOW,  32'(wl));
      csr_write(REG_INIT_X_HIGH, 32'(wh));
      csr_write(REG_BOX_X_LOW,   32'(bl));
      csr_write(REG_BOX_X_HIGH,  32'(bh));
      csr_write(REG_Y_HALF,      32'(hh));
      csr_write(REG_TARGET_X,    32'(gx));
      csr_write(REG_STEP_LIMIT,  32'(lim));
      win_lo = wl; win_hi = wh; box_lo = bl; box_hi = bh;
      half_h = hh; goal_x = gx; tick_limit = lim;
   endtask

   task automatic send_seed(input logic [63:0] seed);
      seed_queue.push_back(seed);
      outcome_queue.push_back(first_passage(seed));
   endtask

   // Every seed yields exactly one result, so an empty outcome queue means idle.
   task automatic drain;
      while (seed_queue.size() != 0 || outcome_queue.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   function automatic logic [63:0] any_seed;
      return {$urandom, $urandom};
   endfunction

   // Idling is switched off for the first stretch of every counter period, and otherwise comes at random.
   function automatic bit take_gap;
      if ((cycle_count % 40000) < 12000) return 1'b0;
      return $urandom_range(99, 0) < 9;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cycle_count <= 0;
         req_fire    <= 1'b0;
      end else begin
         cycle_count <= cycle_count + 1;
         req_fire    <= req_valid && !req_stall;
      end
   end

   // Driver: a held seed stays put until it is transferred.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= take_gap();
         if (!req_valid || req_fire) begin
            if (req_fire) void'(seed_queue.pop_front());
            if (seed_queue.size() > 0 && !take_gap()) begin
               req_valid <= 1'b1;
               req_seed  <= seed_queue[0];
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: each result transfer is matched against the oldest expected outcome.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (outcome_queue.size() == 0) begin
            $display("%0t: unexpected result first_time=%0d status=%0d",
                     $time, rsp_first_time, rsp_status);
            errors++;
         end else begin
            if (rsp_first_time !== outcome_queue[0].first_time) begin
               $display("%0t: first_time expected %0d actual %0d",
                        $time, outcome_queue[0].first_time, rsp_first_time);
               errors++;
            end
            if (rsp_status !== outcome_queue[0].status) begin
               $display("%0t: status expected %0d actual %0d",
                        $time, outcome_queue[0].status, rsp_status);
               errors++;
            end
            case (outcome_queue[0].status)
               ST_REACHED: reached_runs++;
               ST_LIMIT:   limit_runs++;
               default:    bad_runs++;
            endcase
            checked++;
            void'(outcome_queue.pop_front());
         end
      end
   end

   initial begin
      int p, k;
      errors = 0; checked = 0;
      reached_runs = 0; limit_runs = 0; bad_runs = 0;
      reset = 1'b1;
      req_valid = 1'b0; req_seed = '0; rsp_stall = 1'b0;
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
      csr_paddr = '0; csr_pwdata = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Target at the origin finishes at once; also covers the seed extremes.
      set_geometry(-4, 4, -6, 6, 2, 0, 10);
      send_seed(64'd0);
      send_seed({64{1'b1}});
      send_seed(any_seed());
      drain();

      // A window of more sites than the map holds is rejected.
      set_geometry(-100, 1100, -200, 1200, 32767, 1000, 200000);
      send_seed(any_seed());
      send_seed(any_seed());
      drain();

      // Zero step limit is rejected as well.
      set_geometry(-3, 3, -3, 3, 1, 2, 0);
      send_seed(any_seed());
      drain();

      // Widest window and box on a single row, target out of practical reach.
      set_geometry(-32768, 32767, -32768, 32767, 0, 32767, 30);
      send_seed(any_seed());
      send_seed(any_seed());
      drain();

      // Largest step limit, but a two-site box on one row reaches x=1 quickly.
      set_geometry(-3, 3, 0, 1, 0, 1, 32'h7FFF_FFFF);
      send_seed(any_seed());
      send_seed(any_seed());
      drain();

      // A box of one column pins frogs at x=0; the run hits the step limit.
      set_geometry(-2, 2, 0, 0, 2, 2, 20);
      send_seed(any_seed());
      send_seed(any_seed());
      drain();

      // Random small geometries keep each run short while varying every outcome.
      for (p = 0; p < 10; p++) begin
         set_geometry(-$urandom_range(4, 0), $urandom_range(6, 0),
                      -$urandom_range(6, 0), $urandom_range(8, 0),
                      $urandom_range(2, 0), $urandom_range(4, 1),
                      $urandom_range(40, 1));
         for (k = 0; k < 10; k++) send_seed(any_seed());
         drain();
      end

      $display("Checked %0d runs: %0d reached the target, %0d ran out of ticks,",
               checked, reached_runs, limit_runs);
      $display("%0d rejected for geometry or zero limit.", bad_runs);
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #(64'd12 * 64'd60_000_000);
      $display("Some tests failed");
      $finish;
   end

endmodule
